// File: hw/rtl/nft_pkg.sv
package nft_pkg;

    // Coordinate and size formats
    localparam int COORD_BITS  = 12;
    localparam int SIZE_BITS   = COORD_BITS - 1;
    localparam int CENTRE_BITS = COORD_BITS + 1;
    localparam int DIFF_BITS   = COORD_BITS + 2;
    localparam int SCORE_BITS  = 26;
    localparam int BEAR_BITS   = 16;
    localparam int FW_BITS     = 11;
    localparam int PXD_BITS    = 12;
    localparam int BUCKET_BITS = 4;

    localparam int COORD_MAX = 2 ** (COORD_BITS - 1) - 1;
    localparam int COORD_MIN = -(2 ** (COORD_BITS - 1));

    localparam logic [SCORE_BITS-1:0]  SCORE_MAX   = '1;
    localparam int                     CLICK_HALF  = 50;
    localparam logic [SIZE_BITS-1:0]   CLICK_SIZE  = SIZE_BITS'(100);
    localparam int                     THRESHOLD_COUNT = 15;
    localparam logic [BUCKET_BITS-1:0] BUCKET_NONE = 4'd15;

    // Configuration reset values
    localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RESET = 11'd960;
    localparam logic [PXD_BITS-1:0] PRINCIPAL_RESET   = 12'd1919;

    // Register index (paddr[2])
    localparam logic REG_FRAME_WIDTH = 1'b0;
    localparam logic REG_PRINCIPAL   = 1'b1;

    // Input op codes
    localparam logic [1:0] OP_FACE      = 2'd0;
    localparam logic [1:0] OP_FRAME_END = 2'd1;
    localparam logic [1:0] OP_LEFT      = 2'd2;
    localparam logic [1:0] OP_RIGHT     = 2'd3;

    // Item class decided by the front
    typedef enum logic [2:0] {
        KIND_CAND,
        KIND_CAND_LAST,
        KIND_FRAME_END,
        KIND_CLICK_LEFT,
        KIND_CLICK_RIGHT
    } kind_t;

    typedef struct packed {
        logic [1:0]                   op;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic [SIZE_BITS-1:0]         box_w;
        logic [SIZE_BITS-1:0]         box_h;
        logic                         last;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] face_x;
        logic signed [COORD_BITS-1:0] face_y;
        logic [SIZE_BITS-1:0]         face_w;
        logic [SIZE_BITS-1:0]         face_h;
        logic [BUCKET_BITS-1:0]       bearing_bucket;
        logic                         locked;
    } out_item_t;

    // Queue entry: box (or click seed) plus precomputed center
    typedef struct packed {
        kind_t                         kind;
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic [SIZE_BITS-1:0]          w;
        logic [SIZE_BITS-1:0]          h;
        logic signed [CENTRE_BITS-1:0] cx;
        logic signed [CENTRE_BITS-1:0] cy;
    } q_item_t;

    typedef struct packed {
        logic [FW_BITS-1:0]  view_width;
        logic [PXD_BITS-1:0] principal_x_doubled;
    } cfg_t;

    // Bearing thresholds, ceil(3035.2046*tan(a)) for a = -26..30 deg in 4 deg steps
    function automatic logic signed [BEAR_BITS-1:0] bearing_thr(input logic [BUCKET_BITS-1:0] idx);
        logic signed [BEAR_BITS-1:0] t;
        unique case (idx)
            4'd0:    t = -16'sd1480;
            4'd1:    t = -16'sd1226;
            4'd2:    t = -16'sd986;
            4'd3:    t = -16'sd756;
            4'd4:    t = -16'sd535;
            4'd5:    t = -16'sd319;
            4'd6:    t = -16'sd105;
            4'd7:    t = 16'sd106;
            4'd8:    t = 16'sd320;
            4'd9:    t = 16'sd536;
            4'd10:   t = 16'sd757;
            4'd11:   t = 16'sd987;
            4'd12:   t = 16'sd1227;
            4'd13:   t = 16'sd1481;
            default: t = 16'sd1753;
        endcase
        return t;
    endfunction

endpackage

// File: hw/rtl/nft_front.sv
module nft_front
    import nft_pkg::*;
(
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    input  logic     q_full,
    output logic     q_push,
    output q_item_t  q_wdata
);

    logic signed [CENTRE_BITS-1:0] seed_x;
    logic signed [CENTRE_BITS-1:0] seed_y;
    logic signed [COORD_BITS-1:0]  sat_x;
    logic signed [COORD_BITS-1:0]  sat_y;

    // Transfer whenever the queue has room
    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    // Click seed: point minus half box, saturated to the coordinate range
    always_comb
    begin
        seed_x = CENTRE_BITS'(item.pos_x) - CENTRE_BITS'(CLICK_HALF);
        seed_y = CENTRE_BITS'(item.pos_y) - CENTRE_BITS'(CLICK_HALF);
        if (seed_x > COORD_MAX)
            sat_x = COORD_BITS'(COORD_MAX);
        else if (seed_x < COORD_MIN)
            sat_x = COORD_BITS'(COORD_MIN);
        else
            sat_x = COORD_BITS'(seed_x);
        if (seed_y > COORD_MAX)
            sat_y = COORD_BITS'(COORD_MAX);
        else if (seed_y < COORD_MIN)
            sat_y = COORD_BITS'(COORD_MIN);
        else
            sat_y = COORD_BITS'(seed_y);
    end

    // Classify and compute box centre
    always_comb
    begin
        q_wdata.x  = item.pos_x;
        q_wdata.y  = item.pos_y;
        q_wdata.w  = item.box_w;
        q_wdata.h  = item.box_h;
        q_wdata.cx = CENTRE_BITS'(item.pos_x)
                   + $signed(CENTRE_BITS'(item.box_w[SIZE_BITS-1:1]));
        q_wdata.cy = CENTRE_BITS'(item.pos_y)
                   + $signed(CENTRE_BITS'(item.box_h[SIZE_BITS-1:1]));
        unique case (item.op)
            OP_FACE:      q_wdata.kind = item.last ? KIND_CAND_LAST : KIND_CAND;
            OP_FRAME_END: q_wdata.kind = KIND_FRAME_END;
            OP_LEFT:
            begin
                q_wdata.kind = KIND_CLICK_LEFT;
                q_wdata.x    = sat_x;
                q_wdata.y    = sat_y;
            end
            OP_RIGHT:
            begin
                q_wdata.kind = KIND_CLICK_RIGHT;
                q_wdata.x    = sat_x;
                q_wdata.y    = sat_y;
            end
        endcase
    end

endmodule

// File: hw/rtl/nft_queue.sv
module nft_queue
    import nft_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t wdata,
    output logic    full,
    input  logic    pop,
    output logic    rd_valid,
    output q_item_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_item_t           mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rdata    = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !rd_valid))
        else $error("pop from empty queue");

endmodule

// File: hw/rtl/nft_back.sv
module nft_back
    import nft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  q_item_t   q_item,
    output logic      q_pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    // Tracking state
    logic signed [COORD_BITS-1:0] prior_x_reg, prior_x_next;
    logic signed [COORD_BITS-1:0] prior_y_reg, prior_y_next;
    logic [SIZE_BITS-1:0]         prior_w_reg, prior_w_next;
    logic [SIZE_BITS-1:0]         prior_h_reg, prior_h_next;
    logic                         lock_reg, lock_next;
    logic                         have_best_reg, have_best_next;
    logic signed [COORD_BITS-1:0] best_x_reg, best_x_next;
    logic signed [COORD_BITS-1:0] best_y_reg, best_y_next;
    logic [SIZE_BITS-1:0]         best_w_reg, best_w_next;
    logic [SIZE_BITS-1:0]         best_h_reg, best_h_next;
    logic [SCORE_BITS-1:0]        best_score_reg, best_score_next;
    logic                         result_valid_reg, result_valid_next;
    out_item_t                    result_reg, result_next;

    logic is_cand, is_click, emits, out_free, fire;
    logic peripheral, better, take, adopt;
    logic signed [CENTRE_BITS-1:0] pcx, pcy, npcx;
    logic signed [DIFF_BITS-1:0]   dx, dy, off;
    logic [DIFF_BITS-1:0]          abs_off;
    logic signed [2*DIFF_BITS-1:0] sq_x, sq_y;
    logic [2*DIFF_BITS:0]          sq_dist;
    logic [SCORE_BITS-1:0]         score;
    logic signed [COORD_BITS-1:0]  np_x, np_y;
    logic [SIZE_BITS-1:0]          np_w, np_h;
    logic signed [BEAR_BITS-1:0]   bear;
    logic [BUCKET_BITS-1:0]        bucket;

    // Item class and flow control
    assign is_cand  = (q_item.kind == KIND_CAND) || (q_item.kind == KIND_CAND_LAST);
    assign is_click = (q_item.kind == KIND_CLICK_LEFT) || (q_item.kind == KIND_CLICK_RIGHT);
    assign emits    = (q_item.kind == KIND_CAND_LAST) || (q_item.kind == KIND_FRAME_END);
    assign out_free = !result_valid_reg || !result_stall;
    assign fire     = q_valid && (!emits || out_free);
    assign q_pop    = fire;

    // Candidate score: offset from frame center, or squared distance to prior center
    always_comb
    begin
        peripheral = (prior_x_reg == '0);
        pcx  = CENTRE_BITS'(prior_x_reg) + $signed(CENTRE_BITS'(prior_w_reg[SIZE_BITS-1:1]));
        pcy  = CENTRE_BITS'(prior_y_reg) + $signed(CENTRE_BITS'(prior_h_reg[SIZE_BITS-1:1]));
        dx   = DIFF_BITS'(q_item.cx) - DIFF_BITS'(pcx);
        dy   = DIFF_BITS'(q_item.cy) - DIFF_BITS'(pcy);
        sq_x = dx * dx;
        sq_y = dy * dy;
        sq_dist = (2*DIFF_BITS+1)'($unsigned(sq_x)) + (2*DIFF_BITS+1)'($unsigned(sq_y));
        off  = DIFF_BITS'(q_item.cx)
             - $signed(DIFF_BITS'(cfg.view_width[FW_BITS-1:1]));
        abs_off = off[DIFF_BITS-1] ? $unsigned(-off) : $unsigned(off);
        if (peripheral)
            score = SCORE_BITS'(abs_off);
        else if (sq_dist > (2*DIFF_BITS+1)'(SCORE_MAX))
            score = SCORE_MAX;
        else
            score = sq_dist[SCORE_BITS-1:0];
        if (!have_best_reg)
            better = 1'b1;
        else if (peripheral)
            better = score > best_score_reg;
        else
            better = score < best_score_reg;
        take = is_cand && !lock_reg && better;
    end

    // Prior box after a frame end, and its bearing bucket
    always_comb
    begin
        adopt = !lock_reg && (have_best_reg || take);
        np_x  = prior_x_reg;
        np_y  = prior_y_reg;
        np_w  = prior_w_reg;
        np_h  = prior_h_reg;
        if (adopt)
        begin
            np_x = take ? q_item.x : best_x_reg;
            np_y = take ? q_item.y : best_y_reg;
            np_w = take ? q_item.w : best_w_reg;
            np_h = take ? q_item.h : best_h_reg;
        end
        npcx = CENTRE_BITS'(np_x) + $signed(CENTRE_BITS'(np_w[SIZE_BITS-1:1]));
        bear = (BEAR_BITS'(npcx) <<< 2)
             - $signed(BEAR_BITS'(cfg.principal_x_doubled));
        // first threshold above the bearing wins
        bucket = BUCKET_NONE;
        for (int i = THRESHOLD_COUNT - 1; i >= 0; i--)
        begin
            if (bear < bearing_thr(BUCKET_BITS'(i)))
                bucket = BUCKET_BITS'(i);
        end
    end

    // Next state
    always_comb
    begin
        prior_x_next      = prior_x_reg;
        prior_y_next      = prior_y_reg;
        prior_w_next      = prior_w_reg;
        prior_h_next      = prior_h_reg;
        lock_next         = lock_reg;
        have_best_next    = have_best_reg;
        best_x_next       = best_x_reg;
        best_y_next       = best_y_reg;
        best_w_next       = best_w_reg;
        best_h_next       = best_h_reg;
        best_score_next   = best_score_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if (fire)
        begin
            unique case (q_item.kind)
                KIND_CAND:
                begin
                    if (take)
                    begin
                        best_x_next     = q_item.x;
                        best_y_next     = q_item.y;
                        best_w_next     = q_item.w;
                        best_h_next     = q_item.h;
                        best_score_next = score;
                        have_best_next  = 1'b1;
                    end
                end
                KIND_CAND_LAST, KIND_FRAME_END:
                begin
                    prior_x_next      = np_x;
                    prior_y_next      = np_y;
                    prior_w_next      = np_w;
                    prior_h_next      = np_h;
                    have_best_next    = 1'b0;
                    best_score_next   = '0;
                    result_valid_next = 1'b1;
                    result_next.face_x         = np_x;
                    result_next.face_y         = np_y;
                    result_next.face_w         = np_w;
                    result_next.face_h         = np_h;
                    result_next.bearing_bucket = bucket;
                    result_next.locked         = lock_reg;
                end
                KIND_CLICK_LEFT, KIND_CLICK_RIGHT:
                begin
                    prior_x_next   = q_item.x;
                    prior_y_next   = q_item.y;
                    prior_w_next   = CLICK_SIZE;
                    prior_h_next   = CLICK_SIZE;
                    lock_next      = (q_item.kind == KIND_CLICK_RIGHT);
                    have_best_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and tracked state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_x_reg      <= '0;
            prior_y_reg      <= '0;
            prior_w_reg      <= '0;
            prior_h_reg      <= '0;
            lock_reg         <= 1'b0;
            have_best_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            prior_x_reg      <= prior_x_next;
            prior_y_reg      <= prior_y_next;
            prior_w_reg      <= prior_w_next;
            prior_h_reg      <= prior_h_next;
            lock_reg         <= lock_next;
            have_best_reg    <= have_best_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload, qualified by have_best / result_valid
    always_ff @(posedge clk)
    begin
        best_x_reg     <= best_x_next;
        best_y_reg     <= best_y_next;
        best_w_reg     <= best_w_next;
        best_h_reg     <= best_h_next;
        best_score_reg <= best_score_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_click_drops_best: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_click |=> !have_best_reg)
        else $error("running best survived a click");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(fire && emits))
        else $error("result raised without a frame end");

    a_lock_holds_prior: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg && fire && is_cand |=>
            prior_x_reg == $past(prior_x_reg) && prior_w_reg == $past(prior_w_reg))
        else $error("prior box moved while locked");

endmodule

// File: hw/rtl/nearest_face_tracker.sv
// Nearest face tracker.
// item channel: one transfer per candidate box or command (face, frame end,
// left click, right click). result channel: one transfer per frame end,
// carrying the tracked box, bearing bucket and lock flag.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// Configuration over APB: frame width at 0x0, doubled principal column at 0x4,
// write only while idle. pready is tied high.
// Throughput: one item per cycle while item_stall is low. The front
// classifies the item and forms the box center into a QUEUE_DEPTH entry
// queue; the back scores it (two 14x14 squares and a compare against the
// running best) combinationally. A frame end passes through the queue and
// then the result register before its result is offered.
// When the result side stalls, the result register holds and the back stops at
// the next frame end; the queue fills and item_stall rises once it is full.
// Reset clears the tracked box, lock and running best, and restores the
// configuration to 960 and 1919.
module nearest_face_tracker
    import nft_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  in_item_t    item,
    output logic        result_valid,
    input  logic        result_stall,
    output out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [FW_BITS-1:0]  view_width_reg, view_width_next;
    logic [PXD_BITS-1:0] principal_reg, principal_next;
    cfg_t                cfg;
    logic                cfg_write;

    logic    q_full, q_push, q_pop, q_valid;
    q_item_t q_wdata, q_rdata;

    // Register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        view_width_next = view_width_reg;
        principal_next  = principal_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FRAME_WIDTH: view_width_next = pwdata[FW_BITS-1:0];
                REG_PRINCIPAL:   principal_next  = pwdata[PXD_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_WIDTH: prdata = 32'(view_width_reg);
            REG_PRINCIPAL:   prdata = 32'(principal_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_width_reg <= FRAME_WIDTH_RESET;
            principal_reg  <= PRINCIPAL_RESET;
        end
        else
        begin
            view_width_reg <= view_width_next;
            principal_reg  <= principal_next;
        end
    end

    assign cfg.view_width          = view_width_reg;
    assign cfg.principal_x_doubled = principal_reg;

    // Front: accept and classify
    nft_front u_front
    (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    // Decoupling queue
    nft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rdata    (q_rdata)
    );

    // Back: scoring, tracking and result register
    nft_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_item       (q_rdata),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb
    import nft_pkg::*;
();

    localparam int RUN_LIMIT     = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_ITEMS   = 100;
    localparam int CLICK_OFFSET  = 50;
    localparam int CLICK_BOX     = 100;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    in_item_t    item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    out_item_t   result;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    nearest_face_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // tan() steps of the bearing buckets, scaled to the 4*cx domain
    int tan_steps [15] = '{-1480, -1226, -986, -756, -535, -319, -105,
                           106, 320, 536, 757, 987, 1227, 1481, 1753};

    // Tracker model state
    int  trk_x, trk_y, trk_w, trk_h;
    bit  trk_locked;
    int  pick_x, pick_y, pick_w, pick_h, pick_score;
    bit  pick_valid;
    int  cfg_width = int'(FRAME_WIDTH_RESET);
    int  cfg_pxd   = int'(PRINCIPAL_RESET);

    in_item_t  pending [$];
    out_item_t frames_due [$];
    int        items_queued = 0;
    int        items_taken  = 0;
    int        fails        = 0;
    int        cycle_count  = 0;

    // Idle pattern state of both sides
    int in_wait = 0, in_run = 0, out_wait = 0, out_run = 0;
    bit in_quiet = 1'b0, out_quiet = 1'b0;

    initial forever #5 clk = ~clk;

    // Wait draw per transfer; runs of quiet stretches with no idling at all
    task automatic draw_wait(inout int run, inout bit quiet, output int cycles);
        if (run == 0)
        begin
            run   = $urandom_range(10, 40);
            quiet = ($urandom_range(0, 3) == 0);
        end
        run--;
        cycles = quiet ? 0 : int'($urandom_range(0, 5));
    endtask

    function automatic int clip_coord(input int v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // Frame end: adopt the pick, work out the bearing bucket, queue the result
    task automatic close_frame();
        out_item_t f;
        int        d;
        bit        found;
        if (!trk_locked && pick_valid)
        begin
            trk_x = pick_x;
            trk_y = pick_y;
            trk_w = pick_w;
            trk_h = pick_h;
        end
        pick_valid = 1'b0;
        pick_score = 0;
        d = 4 * (trk_x + trk_w / 2) - cfg_pxd;
        f.bearing_bucket = BUCKET_NONE;
        found = 1'b0;
        for (int i = 0; i < THRESHOLD_COUNT; i++)
        begin
            if (!found && d < tan_steps[i])
            begin
                f.bearing_bucket = BUCKET_BITS'(i);
                found = 1'b1;
            end
        end
        f.face_x = COORD_BITS'(trk_x);
        f.face_y = COORD_BITS'(trk_y);
        f.face_w = SIZE_BITS'(trk_w);
        f.face_h = SIZE_BITS'(trk_h);
        f.locked = trk_locked;
        frames_due = {frames_due, f};
    endtask

    // Advance the tracker model by one accepted transfer
    task automatic track_item(input in_item_t it);
        int x, y, w, h, cx, cy, dx, dy, score;
        bit wins;
        x = $signed(it.pos_x);
        y = $signed(it.pos_y);
        w = int'(it.box_w);
        h = int'(it.box_h);
        case (it.op)
            OP_FACE:
            begin
                if (!trk_locked)
                begin
                    cx = x + w / 2;
                    cy = y + h / 2;
                    if (trk_x == 0)
                    begin
                        // no prior box: prefer the candidate farthest from frame center
                        score = cx - cfg_width / 2;
                        if (score < 0)
                            score = -score;
                    end
                    else
                    begin
                        dx = cx - (trk_x + trk_w / 2);
                        dy = cy - (trk_y + trk_h / 2);
                        score = dx * dx + dy * dy;
                    end
                    if (score > int'(SCORE_MAX))
                        score = int'(SCORE_MAX);
                    if (!pick_valid)
                        wins = 1'b1;
                    else if (trk_x == 0)
                        wins = score > pick_score;
                    else
                        wins = score < pick_score;
                    if (wins)
                    begin
                        pick_x = x;
                        pick_y = y;
                        pick_w = w;
                        pick_h = h;
                        pick_score = score;
                        pick_valid = 1'b1;
                    end
                end
                if (it.last)
                    close_frame();
            end
            OP_FRAME_END: close_frame();
            default:
            begin
                // clicks seed a fixed box around the click point
                trk_x = clip_coord(x - CLICK_OFFSET);
                trk_y = clip_coord(y - CLICK_OFFSET);
                trk_w = CLICK_BOX;
                trk_h = CLICK_BOX;
                trk_locked = (it.op == OP_RIGHT);
                pick_valid = 1'b0;
            end
        endcase
    endtask

    function automatic string show_frame(input out_item_t f);
        return $sformatf("box(%0d,%0d,%0d,%0d) bucket %0d lock %0b",
                         f.face_x, f.face_y, f.face_w, f.face_h,
                         f.bearing_bucket, f.locked);
    endfunction

    task automatic log_fail(input string msg);
        fails++;
        if (fails <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic add(input logic [1:0] op, input int x, input int y,
                       input int w, input int h, input logic last);
        in_item_t it;
        it.op    = op;
        it.pos_x = COORD_BITS'(x);
        it.pos_y = COORD_BITS'(y);
        it.box_w = SIZE_BITS'(w);
        it.box_h = SIZE_BITS'(h);
        it.last  = last;
        pending = {pending, it};
        items_queued++;
    endtask

    // Wait until every queued item went in and every frame came out
    task automatic drain();
        while (items_taken != items_queued || frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_FRAME_WIDTH)
            cfg_width = int'(value[FW_BITS-1:0]);
        else
            cfg_pxd = int'(value[PXD_BITS-1:0]);
    endtask

    function automatic int rand_pos();
        if ($urandom_range(0, 1) == 0)
            return int'($urandom_range(0, 4095)) - 2048;
        return int'($urandom_range(0, 1100)) - 50;
    endfunction

    function automatic int rand_size();
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 2047));
        return int'($urandom_range(0, 300));
    endfunction

    // Item side: one transfer at a time from the pending queue
    always @(posedge clk)
    begin : item_side
        logic busy;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            busy = item_valid;
            if (item_valid && !item_stall)
            begin
                track_item(item);
                items_taken++;
                draw_wait(in_run, in_quiet, in_wait);
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (in_wait != 0)
                begin
                    in_wait--;
                    item_valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    item       <= pending.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each frame result against the oldest expected one
    always @(posedge clk)
    begin : result_side
        out_item_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    log_fail({"unexpected result ", show_frame(result)});
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (result.face_x !== want.face_x || result.face_y !== want.face_y ||
                        result.face_w !== want.face_w || result.face_h !== want.face_h ||
                        result.bearing_bucket !== want.bearing_bucket ||
                        result.locked !== want.locked)
                        log_fail({"expected ", show_frame(want), ", got ", show_frame(result)});
                end
                draw_wait(out_run, out_quiet, out_wait);
            end
            result_stall <= (out_wait != 0);
            if (out_wait != 0)
                out_wait--;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int fw_set [5];
        int pxd_set [5];
        int made, roll, n, px, py, pw, ph, cx;
        bit paused, by_last, cut;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset state has no prior box, so the first frame picks the
        // candidate farthest from frame center
        add(OP_FACE, 100, 50, 40, 40, 1'b0);
        add(OP_FACE, 900, 60, 40, 40, 1'b0);
        add(OP_FACE, 20, 0, 80, 40, 1'b1);
        // empty frame keeps the prior, last on a frame end is ignored
        add(OP_FRAME_END, 0, 0, 0, 0, 1'b1);
        // nearest mode, tie keeps the earliest, frame end after open candidates
        add(OP_FACE, 880, 40, 80, 80, 1'b0);
        add(OP_FACE, 890, 50, 60, 60, 1'b0);
        add(OP_FACE, 2047, 2047, 2047, 2047, 1'b0);
        add(OP_FRAME_END, -2048, 2047, 2047, 0, 1'b0);
        add(OP_FACE, -2048, -2048, 0, 0, 1'b1);
        // left click at the corner saturates the seeded box
        add(OP_LEFT, -2048, -2048, 2047, 2047, 1'b1);
        add(OP_FRAME_END, 0, 0, 0, 0, 1'b0);
        // right click locks, candidates are ignored until a left click
        add(OP_RIGHT, 2047, 2047, 0, 0, 1'b0);
        add(OP_FACE, 0, 0, 10, 10, 1'b1);
        add(OP_FACE, 500, 500, 20, 20, 1'b0);
        add(OP_FRAME_END, 0, 0, 0, 0, 1'b0);
        // click at column 50 puts the prior left edge at zero again
        add(OP_LEFT, 50, 300, 0, 0, 1'b0);
        add(OP_FACE, 470, 10, 20, 20, 1'b0);
        add(OP_FACE, 490, 10, 0, 0, 1'b0);
        add(OP_FACE, 460, 0, 40, 40, 1'b1);
        // click mid frame drops the running pick
        add(OP_FACE, 100, 100, 50, 50, 1'b0);
        add(OP_LEFT, 600, 400, 1, 1, 1'b1);
        add(OP_FRAME_END, 0, 0, 0, 0, 1'b0);
        add(OP_FACE, 1023, -1, 1, 2047, 1'b1);
        add(OP_RIGHT, 0, 0, 0, 0, 1'b1);
        add(OP_LEFT, 50, 50, 0, 0, 1'b0);
        add(OP_FRAME_END, 0, 0, 0, 0, 1'b1);
        drain();

        fw_set  = '{0, 2047, int'($urandom_range(0, 2047)), int'($urandom_range(0, 2047)),
                    int'(FRAME_WIDTH_RESET)};
        pxd_set = '{0, 4095, int'($urandom_range(0, 4095)), int'($urandom_range(0, 4095)),
                    int'(PRINCIPAL_RESET)};
        paused = 1'b0;
        px = 0;
        py = 0;
        pw = 0;
        ph = 0;

        for (int ph_i = 0; ph_i < 5; ph_i++)
        begin
            write_reg(REG_FRAME_WIDTH, 32'(fw_set[ph_i]));
            write_reg(REG_PRINCIPAL, 32'(pxd_set[ph_i]));
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                // hold off the sender once until the block has fully drained
                if (ph_i == 1 && made >= PHASE_ITEMS / 2 && !paused)
                begin
                    drain();
                    paused = 1'b1;
                end
                roll = $urandom_range(0, 99);
                cx = ($urandom_range(0, 2) == 0) ? CLICK_OFFSET : rand_pos();
                if (roll < 7)
                begin
                    add(OP_LEFT, cx, rand_pos(), rand_size(), rand_size(),
                        1'($urandom_range(0, 1)));
                    made++;
                end
                else if (roll < 11)
                begin
                    add(OP_RIGHT, cx, rand_pos(), rand_size(), rand_size(),
                        1'($urandom_range(0, 1)));
                    made++;
                end
                else if (roll < 16)
                begin
                    add(OP_FRAME_END, rand_pos(), rand_pos(), rand_size(), rand_size(),
                        1'($urandom_range(0, 1)));
                    made++;
                end
                else
                begin
                    // a frame of candidates, mostly closed by last
                    n       = $urandom_range(1, 6);
                    by_last = ($urandom_range(0, 6) != 0);
                    cut     = ($urandom_range(0, 19) == 0);
                    for (int k = 0; k < n; k++)
                    begin
                        if (k != 0 && $urandom_range(0, 9) == 0)
                        begin
                            // same center as the previous box, different box
                            pw = pw ^ 1;
                            ph = ph ^ 1;
                        end
                        else
                        begin
                            px = ($urandom_range(0, 19) == 0) ? 0 : rand_pos();
                            py = rand_pos();
                            pw = rand_size();
                            ph = rand_size();
                        end
                        add(OP_FACE, px, py, pw, ph, by_last && !cut && k == n - 1);
                        made++;
                    end
                    if (!by_last && !cut)
                    begin
                        add(OP_FRAME_END, rand_pos(), rand_pos(), rand_size(), rand_size(),
                            1'($urandom_range(0, 1)));
                        made++;
                    end
                end
            end
            drain();
        end

        if (frames_due.size() != 0)
            log_fail($sformatf("%0d frames never arrived", frames_due.size()));
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
